// ===== src/leaky_bucket_packet_admitter_unit_macros.svh =====
// Assertion macros shared by the leaky bucket packet admitter RTL.
`ifndef LEAKY_BUCKET_PACKET_ADMITTER_UNIT_MACROS_SVH
`define LEAKY_BUCKET_PACKET_ADMITTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define LBPA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("lbpa: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define LBPA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("lbpa: next-cycle check failed");
`else
`define LBPA_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define LBPA_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== src/lbpa_pkg.sv =====
// Shared types, register codes and constants of the leaky bucket packet admitter.
package lbpa_pkg;

	localparam int SCHEDULE_DEPTH_DEF = 4;
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_RATE     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LIMIT  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCHED_LENGTH  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCHED_ENTRY0  = 4'd4;

	localparam logic [23:0] BASE_RATE_RST    = 24'd62500;
	localparam logic [7:0]  HEADER_BYTES_RST = 8'd28;
	localparam logic [23:0] BUFFER_LIMIT_RST = 24'd65536;
	localparam logic [31:0] SWITCH_TIME_RST  = 32'd1073741824;

	// A drain product at or above 1000 * 2^24 empties any 24-bit backlog.
	localparam logic [63:0] DRAIN_SAT = 64'd16777216000;
	// floor(p / 1000) = floor((p >> 3) * RECIP_M >> RECIP_SHIFT) for p < DRAIN_SAT.
	localparam logic [31:0] RECIP_M     = 32'd2199023256;
	localparam int          RECIP_SHIFT = 38;

	typedef struct packed {
		logic [23:0] base_rate;
		logic [7:0]  header_bytes;
		logic [23:0] buffer_limit;
		logic [2:0]  schedule_length;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic [23:0] rate;
	} base_wr_t;

	typedef struct packed {
		logic        sw;
		logic [16:0] add_bytes;
		logic [63:0] prod;
	} s2_t;

	typedef struct packed {
		logic        sw;
		logic [16:0] add_bytes;
		logic        big;
		logic [23:0] dec;
	} s3_t;

	typedef struct packed {
		logic        started;
		logic        sw_fire;
		logic [31:0] current_rate;
		logic [31:0] next_switch_time;
	} sched_status_t;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

// ===== src/lbpa_ifs.sv =====
// Channel interfaces of the leaky bucket packet admitter: packets, verdicts, configuration.
interface lbpa_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic [15:0] packet_len;
	modport source (output valid, output now_ms, output packet_len, input ready);
	modport sink (input valid, input now_ms, input packet_len, output ready);
endinterface

interface lbpa_rsp_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [23:0] backlog_bytes;
	modport source (output valid, output accepted, output backlog_bytes, input ready);
	modport sink (input valid, input accepted, input backlog_bytes, output ready);
endinterface

interface lbpa_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [lbpa_pkg::CFG_IDX_W-1:0] index;
	logic [63:0]                    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/lbpa_cfg_regs.sv =====
// Configuration register file with the schedule entries.
module lbpa_cfg_regs #(
	parameter int SCHEDULE_DEPTH = lbpa_pkg::SCHEDULE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	lbpa_cfg_if.sink            cfg,
	output lbpa_pkg::cfg_t      regs,
	output logic [63:0]         entries [SCHEDULE_DEPTH],
	output lbpa_pkg::base_wr_t  base_wr
);

	logic rdy_q;
	logic wr;

	assign cfg.ready = rdy_q;
	assign wr = cfg.valid && rdy_q;

	assign base_wr.valid = wr && (cfg.index == lbpa_pkg::REG_BASE_RATE);
	assign base_wr.rate  = cfg.data[23:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_q                <= 1'b0;
			regs.base_rate       <= lbpa_pkg::BASE_RATE_RST;
			regs.header_bytes    <= lbpa_pkg::HEADER_BYTES_RST;
			regs.buffer_limit    <= lbpa_pkg::BUFFER_LIMIT_RST;
			regs.schedule_length <= 3'd0;
			for (int i = 0; i < SCHEDULE_DEPTH; i++) begin
				entries[i] <= 64'd0;
			end
		end else begin
			rdy_q <= 1'b1;
			if (wr) begin
				case (cfg.index)
					lbpa_pkg::REG_BASE_RATE:    regs.base_rate       <= cfg.data[23:0];
					lbpa_pkg::REG_HEADER_BYTES: regs.header_bytes    <= cfg.data[7:0];
					lbpa_pkg::REG_BUFFER_LIMIT: regs.buffer_limit    <= cfg.data[23:0];
					lbpa_pkg::REG_SCHED_LENGTH: regs.schedule_length <= cfg.data[2:0];
					default: begin
					end
				endcase
				// Entries past the configured depth are never read and are dropped.
				for (int i = 0; i < SCHEDULE_DEPTH; i++) begin
					if (cfg.index == lbpa_pkg::REG_SCHED_ENTRY0 + lbpa_pkg::CFG_IDX_W'(i)) begin
						entries[i] <= cfg.data;
					end
				end
			end
		end
	end

endmodule

// ===== src/lbpa_sched_stage.sv =====
// Schedule tracking, elapsed time and drain product for one packet.
module lbpa_sched_stage #(
	parameter int SCHEDULE_DEPTH = lbpa_pkg::SCHEDULE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lbpa_pkg::cfg_t          regs,
	input  logic [63:0]             entries [SCHEDULE_DEPTH],
	input  lbpa_pkg::base_wr_t      base_wr,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [31:0]             now_ms,
	input  logic [15:0]             packet_len,
	output logic                    out_valid,
	input  logic                    out_ready,
	output lbpa_pkg::s2_t           s2,
	output lbpa_pkg::sched_status_t status
);

	localparam int LEN_W = $clog2(SCHEDULE_DEPTH + 1);
	localparam int IDX_W = (SCHEDULE_DEPTH > 1) ? $clog2(SCHEDULE_DEPTH) : 1;

	logic [31:0]      last_time_q;
	logic [31:0]      current_rate_q;
	logic [31:0]      next_switch_q;
	logic [IDX_W-1:0] next_index_q;
	logic             started_q;
	logic             v_q;
	lbpa_pkg::s2_t    s2_q;

	logic [LEN_W-1:0] len;
	logic             start;
	logic             sw;
	logic             take;
	logic [31:0]      rate_a;
	logic [31:0]      nst_a;
	logic [IDX_W-1:0] nidx_a;
	logic [IDX_W-1:0] sel_idx;
	logic [63:0]      entry;
	logic [31:0]      rate_n;
	logic [31:0]      nst_n;
	logic [IDX_W-1:0] nidx_n;
	logic [31:0]      elapsed;

	function automatic logic [IDX_W-1:0] next_after(input logic [IDX_W-1:0] idx,
			input logic [LEN_W-1:0] n);
		logic [LEN_W-1:0] nx;
		nx = LEN_W'(idx) + LEN_W'(1);
		return (nx >= n) ? '0 : IDX_W'(nx);
	endfunction

	assign len = (regs.schedule_length > 3'(SCHEDULE_DEPTH)) ? LEN_W'(SCHEDULE_DEPTH)
		: regs.schedule_length[LEN_W-1:0];
	assign start = (len != '0) && !started_q;

	always_comb begin
		if (start) begin
			rate_a = entries[0][63:32];
			nst_a  = lbpa_pkg::sat_add32(now_ms, entries[0][31:0]);
			nidx_a = next_after('0, len);
			// A fresh switch time is already due only for a zero period or at the last tick.
			sw     = (entries[0][31:0] == 32'd0) || (&now_ms);
		end else begin
			rate_a = current_rate_q;
			nst_a  = next_switch_q;
			nidx_a = next_index_q;
			sw     = (len != '0) && (now_ms >= next_switch_q);
		end

		sel_idx = (LEN_W'(nidx_a) >= len) ? '0 : nidx_a;
		entry   = entries[0];
		for (int i = 0; i < SCHEDULE_DEPTH; i++) begin
			if (IDX_W'(i) == sel_idx) begin
				entry = entries[i];
			end
		end

		rate_n = sw ? entry[63:32] : rate_a;
		nst_n  = sw ? lbpa_pkg::sat_add32(now_ms, entry[31:0]) : nst_a;
		nidx_n = sw ? next_after(sel_idx, len) : nidx_a;

		elapsed = (now_ms >= last_time_q) ? (now_ms - last_time_q) : 32'd0;
	end

	assign in_ready = !v_q || out_ready;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q    <= 32'd0;
			current_rate_q <= {8'd0, lbpa_pkg::BASE_RATE_RST};
			next_switch_q  <= lbpa_pkg::SWITCH_TIME_RST;
			next_index_q   <= '0;
			started_q      <= 1'b0;
			v_q            <= 1'b0;
		end else begin
			if (in_ready) begin
				v_q <= in_valid;
			end
			if (base_wr.valid && !started_q) begin
				current_rate_q <= {8'd0, base_wr.rate};
			end else if (take) begin
				current_rate_q <= rate_n;
			end
			if (take) begin
				last_time_q   <= now_ms;
				next_switch_q <= nst_n;
				next_index_q  <= nidx_n;
				started_q     <= started_q || start;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			s2_q.sw        <= sw;
			s2_q.add_bytes <= {1'b0, packet_len} + {9'd0, regs.header_bytes};
			s2_q.prod      <= {32'd0, elapsed} * {32'd0, rate_a};
		end
	end

	assign out_valid = v_q;
	assign s2        = s2_q;

	assign status.started          = started_q;
	assign status.sw_fire          = take && sw;
	assign status.current_rate     = current_rate_q;
	assign status.next_switch_time = next_switch_q;

endmodule

// ===== src/lbpa_div_stage.sv =====
// Divides the drain product by 1000 through a reciprocal multiply, flagging large drains.
module lbpa_div_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lbpa_pkg::s2_t s2,
	output logic          out_valid,
	input  logic          out_ready,
	output lbpa_pkg::s3_t s3
);

	logic          v_q;
	lbpa_pkg::s3_t s3_q;
	logic [30:0]   p_div8;
	logic [62:0]   qprod;
	logic          big;

	assign big    = s2.prod >= lbpa_pkg::DRAIN_SAT;
	assign p_div8 = s2.prod[33:3];
	assign qprod  = {32'd0, p_div8} * {31'd0, lbpa_pkg::RECIP_M};

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			s3_q.sw        <= s2.sw;
			s3_q.add_bytes <= s2.add_bytes;
			s3_q.big       <= big;
			s3_q.dec       <= qprod[lbpa_pkg::RECIP_SHIFT+23:lbpa_pkg::RECIP_SHIFT];
		end
	end

	assign out_valid = v_q;
	assign s3        = s3_q;

endmodule

// ===== src/lbpa_backlog_stage.sv =====
// Backlog drain, admission decision and the result register.
module lbpa_backlog_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [23:0]   buffer_limit,
	input  logic          in_valid,
	output logic          in_ready,
	input  lbpa_pkg::s3_t s3,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          accepted,
	output logic [23:0]   backlog_bytes
);

	logic        v_q;
	logic [23:0] backlog_q;
	logic        accepted_q;
	logic [23:0] result_q;
	logic [23:0] drained;
	logic [24:0] total;
	logic        ok;
	logic [23:0] backlog_n;
	logic        take;

	always_comb begin
		if (s3.big || (s3.dec >= backlog_q)) begin
			drained = 24'd0;
		end else begin
			drained = backlog_q - s3.dec;
		end
		// A schedule switch starts the new period with an empty bucket.
		if (s3.sw) begin
			drained = 24'd0;
		end
		total     = {1'b0, drained} + {8'd0, s3.add_bytes};
		ok        = total <= {1'b0, buffer_limit};
		backlog_n = ok ? total[23:0] : drained;
	end

	assign in_ready = !v_q || out_ready;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q       <= 1'b0;
			backlog_q <= 24'd0;
		end else begin
			if (in_ready) begin
				v_q <= in_valid;
			end
			if (take) begin
				backlog_q <= backlog_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			accepted_q <= ok;
			result_q   <= backlog_n;
		end
	end

	assign out_valid     = v_q;
	assign accepted      = accepted_q;
	assign backlog_bytes = result_q;

endmodule

// ===== src/leaky_bucket_packet_admitter_unit.sv =====
// Top level of the leaky bucket packet admitter.
//
// Usage: each transaction on req carries a packet length and its millisecond
// timestamp; for every one the block returns exactly one transaction on rsp
// with the admit verdict and the backlog left after the decision. The cfg
// channel writes the rate, header allowance, buffer limit and the cyclic rate
// schedule; it should only be used while no packet is in flight.
//
// Throughput is one packet per clock cycle while rsp.ready is held high. The
// packet passes an input register, the schedule stage with the elapsed-time by
// rate multiply, the divide-by-1000 stage with its reciprocal multiply, and the
// backlog stage whose update of the backlog register is what carries the
// dependency from one packet to the next.
//
// Reset clears the backlog, the time and schedule state and all pipeline valid
// bits, and restores the register defaults; cfg.ready is registered and rises
// in the cycle after reset is released. When the receiver holds rsp.ready low
// the result waits in its register, and each stage keeps accepting while a bubble
// lies ahead of it, so up to four packets are buffered before req.ready drops.
`include "leaky_bucket_packet_admitter_unit_macros.svh"

module leaky_bucket_packet_admitter_unit #(
	parameter int SCHEDULE_DEPTH = lbpa_pkg::SCHEDULE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	lbpa_req_if.sink     req,
	lbpa_rsp_if.source   rsp,
	lbpa_cfg_if.sink     cfg
);

	lbpa_pkg::cfg_t          regs;
	lbpa_pkg::base_wr_t      base_wr;
	logic [63:0]             entries [SCHEDULE_DEPTH];
	lbpa_pkg::sched_status_t sched_status;

	// Input register: the packet is captured before any arithmetic is done on it.
	logic        v_s1;
	logic [31:0] now_s1;
	logic [15:0] len_s1;
	logic        sched_ready;

	lbpa_pkg::s2_t s2;
	logic          v_s2;
	logic          div_ready;
	lbpa_pkg::s3_t s3;
	logic          v_s3;
	logic          backlog_ready;

	assign req.ready = !v_s1 || sched_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			now_s1 <= req.now_ms;
			len_s1 <= req.packet_len;
		end
	end

	// Configuration registers and the schedule table.
	lbpa_cfg_regs #(
		.SCHEDULE_DEPTH(SCHEDULE_DEPTH)
	) u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.regs    (regs),
		.entries (entries),
		.base_wr (base_wr)
	);

	// Schedule start and switches, elapsed time and the drain product.
	lbpa_sched_stage #(
		.SCHEDULE_DEPTH(SCHEDULE_DEPTH)
	) u_sched_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.regs       (regs),
		.entries    (entries),
		.base_wr    (base_wr),
		.in_valid   (v_s1),
		.in_ready   (sched_ready),
		.now_ms     (now_s1),
		.packet_len (len_s1),
		.out_valid  (v_s2),
		.out_ready  (div_ready),
		.s2         (s2),
		.status     (sched_status)
	);

	// Drain product to bytes: exact floor division by 1000.
	lbpa_div_stage u_div_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (div_ready),
		.s2        (s2),
		.out_valid (v_s3),
		.out_ready (backlog_ready),
		.s3        (s3)
	);

	// Backlog update and admission; its output register drives rsp.
	lbpa_backlog_stage u_backlog_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.buffer_limit  (regs.buffer_limit),
		.in_valid      (v_s3),
		.in_ready      (backlog_ready),
		.s3            (s3),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.accepted      (rsp.accepted),
		.backlog_bytes (rsp.backlog_bytes)
	);

	// Once the schedule has started it stays started until reset.
	`LBPA_ASSERT_NXT(a_started_sticky, clk, arst_n, sched_status.started, sched_status.started)

	// A base rate write before the schedule starts takes effect on the drain rate.
	`LBPA_ASSERT_NXT(a_base_rate_loads, clk, arst_n, base_wr.valid && !sched_status.started,
		sched_status.current_rate == {8'd0, $past(base_wr.rate)})

	// A switch never schedules the next one earlier than the packet that caused it.
	`LBPA_ASSERT_NXT(a_switch_not_past, clk, arst_n, sched_status.sw_fire,
		sched_status.next_switch_time >= $past(now_s1))

endmodule
